/* sv/handshake_option_parser_macros.svh */
// ----------------------------------------------------------------------------
// handshake_option_parser_macros.svh
// Assertion macros used by the handshake option parser RTL.
// ----------------------------------------------------------------------------
`ifndef HANDSHAKE_OPTION_PARSER_MACROS_SVH
`define HANDSHAKE_OPTION_PARSER_MACROS_SVH

// same-cycle implication, checked outside reset
`define HOP_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define HOP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/hop_pkg.sv */
// ----------------------------------------------------------------------------
// hop_pkg
// Types and constants shared by the handshake option parser modules.
// ----------------------------------------------------------------------------
package hop_pkg;

   // default depth of the queue between front and back
   localparam int QUEUE_DEPTH_DEF = 4;

   // packed result width, padded to whole bytes
   localparam int RSP_DATA_W = 256;

   // byte values that the front classifies
   localparam logic [7:0] HANDSHAKE_TYPE = 8'h00;
   localparam logic [7:0] END_CODE       = 8'hff;
   localparam logic [7:0] LAST_CODE      = 8'h09;

   // result outcome codes
   localparam logic [2:0] OUT_INIT       = 3'd0;
   localparam logic [2:0] OUT_CLOSE      = 3'd1;
   localparam logic [2:0] OUT_NOT_INIT   = 3'd2;
   localparam logic [2:0] OUT_BAD_TYPE   = 3'd3;
   localparam logic [2:0] OUT_BAD_METHOD = 3'd4;
   localparam logic [2:0] OUT_NO_END     = 3'd5;
   localparam logic [2:0] OUT_TRUNCATED  = 3'd6;

   // one classified request byte
   typedef struct packed {
      logic [7:0] data;
      logic       start;
      logic       last;
      logic       is_end_code;
      logic       is_zero;
      logic       in_code_range;
   } hop_item_type;

   // one parse result
   typedef struct packed {
      logic [2:0]  outcome;
      logic [31:0] dest_channel;
      logic [31:0] src_channel;
      logic [7:0]  version;
      logic [7:0]  oldest_version;
      logic [15:0] swarm_id_length;
      logic [31:0] method_codes;
      logic [63:0] discard_window;
      logic [7:0]  supported_length;
      logic [31:0] chunk_length;
      logic [16:0] bytes_consumed;
   } hop_result_type;

endpackage

/* sv/hop_front.sv */
// ----------------------------------------------------------------------------
// hop_front
// Accepts request bytes and tags each with the byte classes the parser needs.
// ----------------------------------------------------------------------------
module hop_front
   import hop_pkg::*;
(
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [7:0]   req_data,
   input  logic         req_start,
   input  logic         req_last,
   input  logic         q_full,
   output logic         q_push,
   output hop_item_type q_item
);

   // accept whenever the queue has room
   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   // classify the byte once, ahead of the parser
   always_comb begin
      q_item.data          = req_data;
      q_item.start         = req_start;
      q_item.last          = req_last;
      q_item.is_end_code   = (req_data == END_CODE);
      q_item.is_zero       = (req_data == HANDSHAKE_TYPE);
      q_item.in_code_range = (req_data <= LAST_CODE);
   end

endmodule

/* sv/hop_queue.sv */
// ----------------------------------------------------------------------------
// hop_queue
// Short first-in first-out queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module hop_queue
   import hop_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
)(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  hop_item_type push_item,
   output logic         full,
   input  logic         pop,
   output logic         pop_valid,
   output hop_item_type pop_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   hop_item_type     entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_FULL);
   assign pop_valid = (count_ff != '0);
   assign pop_item  = entries_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* sv/hop_back.sv */
// ----------------------------------------------------------------------------
// hop_back
// Handshake parse sequencer: walks header fields and options, holds option
// values across messages and registers one result per datagram.
// ----------------------------------------------------------------------------
`include "handshake_option_parser_macros.svh"

module hop_back
   import hop_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           q_valid,
   input  hop_item_type   q_item,
   output logic           q_pop,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output hop_result_type rsp_result
);

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_DEST,
      PH_TYPE,
      PH_SRC,
      PH_CODE,
      PH_BYTEVAL,
      PH_SWLEN,
      PH_SKIP,
      PH_WINDOW,
      PH_SUPLEN,
      PH_CHUNK,
      PH_DONE
   } phase_type;

   phase_type      phase_ff, phase_in;
   logic [3:0]     next_code_ff, next_code_in;
   logic [15:0]    fcnt_ff, fcnt_in;
   logic [16:0]    consumed_ff, consumed_in;
   logic [63:0]    shift_ff, shift_in;
   logic [31:0]    dest_ff, dest_in;
   logic [31:0]    src_ff, src_in;
   logic [7:0]     version_ff, version_in;
   logic [7:0]     minver_ff, minver_in;
   logic [31:0]    method_ff, method_in;
   logic [15:0]    swarm_len_ff, swarm_len_in;
   logic [63:0]    window_ff, window_in;
   logic [7:0]     sup_len_ff, sup_len_in;
   logic [31:0]    chunk_ff, chunk_in;
   logic           init_ff, init_in;
   logic           out_valid_ff, out_valid_in;
   hop_result_type out_ff, out_in;

   logic [63:0]    shift_next;
   logic [15:0]    fcnt_dec;
   logic           field_done;
   logic           hit;
   logic [2:0]     outcome;

   // back stalls only while a finished result is still waiting
   assign q_pop      = q_valid && (!out_valid_ff || rsp_ready);
   assign rsp_valid  = out_valid_ff;
   assign rsp_result = out_ff;

   // parse step for one byte
   always_comb begin
      phase_in     = phase_ff;
      next_code_in = next_code_ff;
      fcnt_in      = fcnt_ff;
      consumed_in  = consumed_ff;
      shift_in     = shift_ff;
      dest_in      = dest_ff;
      src_in       = src_ff;
      version_in   = version_ff;
      minver_in    = minver_ff;
      method_in    = method_ff;
      swarm_len_in = swarm_len_ff;
      window_in    = window_ff;
      sup_len_in   = sup_len_ff;
      chunk_in     = chunk_ff;
      init_in      = init_ff;
      shift_next   = '0;
      fcnt_dec     = '0;
      field_done   = 1'b0;
      hit          = 1'b0;
      outcome      = OUT_INIT;

      if (q_pop) begin
         // message start clears channels and counters
         if (q_item.start) begin
            dest_in      = '0;
            src_in       = '0;
            consumed_in  = '0;
            next_code_in = '0;
            init_in      = 1'b0;
            shift_in     = '0;
            fcnt_in      = 16'd4;
            phase_in     = PH_DEST;
         end

         if (phase_in != PH_IDLE && phase_in != PH_DONE) begin
            consumed_in = consumed_in + 17'd1;
            shift_next  = {shift_in[55:0], q_item.data};
            fcnt_dec    = fcnt_in - 16'd1;
            field_done  = (fcnt_dec == 16'd0);

            case (phase_in)
               PH_DEST: begin
                  shift_in = shift_next;
                  fcnt_in  = fcnt_dec;
                  if (field_done) begin
                     dest_in  = shift_next[31:0];
                     phase_in = PH_TYPE;
                  end
               end
               PH_TYPE: begin
                  if (!q_item.is_zero) begin
                     hit         = 1'b1;
                     outcome     = OUT_BAD_TYPE;
                     consumed_in = consumed_in - 17'd1;
                  end else begin
                     shift_in = '0;
                     fcnt_in  = 16'd4;
                     phase_in = PH_SRC;
                  end
               end
               PH_SRC: begin
                  shift_in = shift_next;
                  fcnt_in  = fcnt_dec;
                  if (field_done) begin
                     src_in = shift_next[31:0];
                     if (dest_in != '0 && shift_next[31:0] == '0) begin
                        hit     = 1'b1;
                        outcome = OUT_CLOSE;
                     end else begin
                        init_in  = (dest_in == '0) && (shift_next[31:0] != '0);
                        phase_in = PH_CODE;
                     end
                  end
               end
               PH_CODE: begin
                  if (q_item.is_end_code) begin
                     hit     = 1'b1;
                     outcome = init_in ? OUT_INIT : OUT_NOT_INIT;
                  end else if (q_item.in_code_range &&
                               q_item.data >= {4'd0, next_code_in}) begin
                     next_code_in = q_item.data[3:0] + 4'd1;
                     case (q_item.data[3:0])
                        4'd2: begin
                           shift_in = '0;
                           fcnt_in  = 16'd2;
                           phase_in = PH_SWLEN;
                        end
                        4'd7: begin
                           // window length follows the stored addressing method
                           if (method_in[7:0] inside {8'd0, 8'd2}) begin
                              shift_in = '0;
                              fcnt_in  = 16'd4;
                              phase_in = PH_WINDOW;
                           end else if (method_in[7:0] inside {8'd1, 8'd3, 8'd4}) begin
                              shift_in = '0;
                              fcnt_in  = 16'd8;
                              phase_in = PH_WINDOW;
                           end else begin
                              hit     = 1'b1;
                              outcome = OUT_BAD_METHOD;
                           end
                        end
                        4'd8: begin
                           phase_in = PH_SUPLEN;
                        end
                        4'd9: begin
                           shift_in = '0;
                           fcnt_in  = 16'd4;
                           phase_in = PH_CHUNK;
                        end
                        default: begin
                           phase_in = PH_BYTEVAL;
                        end
                     endcase
                  end else begin
                     // out of order or unknown code
                     hit         = 1'b1;
                     outcome     = OUT_NO_END;
                     consumed_in = consumed_in - 17'd1;
                  end
               end
               PH_BYTEVAL: begin
                  case (next_code_in)
                     4'd1:    version_in        = q_item.data;
                     4'd2:    minver_in         = q_item.data;
                     4'd4:    method_in[31:24]  = q_item.data;
                     4'd5:    method_in[23:16]  = q_item.data;
                     4'd6:    method_in[15:8]   = q_item.data;
                     default: method_in[7:0]    = q_item.data;
                  endcase
                  phase_in = PH_CODE;
               end
               PH_SWLEN: begin
                  shift_in = shift_next;
                  fcnt_in  = fcnt_dec;
                  if (field_done) begin
                     swarm_len_in = shift_next[15:0];
                     if (shift_next[15:0] == '0) begin
                        phase_in = PH_CODE;
                     end else begin
                        shift_in = '0;
                        fcnt_in  = shift_next[15:0];
                        phase_in = PH_SKIP;
                     end
                  end
               end
               PH_SKIP: begin
                  fcnt_in = fcnt_dec;
                  if (field_done) begin
                     phase_in = PH_CODE;
                  end
               end
               PH_WINDOW: begin
                  shift_in = shift_next;
                  fcnt_in  = fcnt_dec;
                  if (field_done) begin
                     window_in = shift_next;
                     phase_in  = PH_CODE;
                  end
               end
               PH_SUPLEN: begin
                  sup_len_in = q_item.data;
                  if (q_item.is_zero) begin
                     phase_in = PH_CODE;
                  end else begin
                     shift_in = '0;
                     fcnt_in  = {8'd0, q_item.data};
                     phase_in = PH_SKIP;
                  end
               end
               PH_CHUNK: begin
                  shift_in = shift_next;
                  fcnt_in  = fcnt_dec;
                  if (field_done) begin
                     chunk_in = shift_next[31:0];
                     phase_in = PH_CODE;
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase

            // last byte of an unfinished parse
            if (!hit && q_item.last) begin
               hit     = 1'b1;
               outcome = OUT_TRUNCATED;
            end
            if (hit) begin
               phase_in = PH_DONE;
            end
         end
      end

      // result register
      out_valid_in = out_valid_ff && !rsp_ready;
      out_in       = out_ff;
      if (hit) begin
         out_valid_in            = 1'b1;
         out_in.outcome          = outcome;
         out_in.dest_channel     = dest_in;
         out_in.src_channel      = src_in;
         out_in.version          = version_in;
         out_in.oldest_version   = minver_in;
         out_in.swarm_id_length  = swarm_len_in;
         out_in.method_codes     = method_in;
         out_in.discard_window   = window_in;
         out_in.supported_length = sup_len_in;
         out_in.chunk_length     = chunk_in;
         out_in.bytes_consumed   = consumed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         next_code_ff <= '0;
         fcnt_ff      <= '0;
         consumed_ff  <= '0;
         shift_ff     <= '0;
         dest_ff      <= '0;
         src_ff       <= '0;
         version_ff   <= '0;
         minver_ff    <= '0;
         method_ff    <= '0;
         swarm_len_ff <= '0;
         window_ff    <= '0;
         sup_len_ff   <= '0;
         chunk_ff     <= '0;
         init_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         out_ff       <= '0;
      end else begin
         phase_ff     <= phase_in;
         next_code_ff <= next_code_in;
         fcnt_ff      <= fcnt_in;
         consumed_ff  <= consumed_in;
         shift_ff     <= shift_in;
         dest_ff      <= dest_in;
         src_ff       <= src_in;
         version_ff   <= version_in;
         minver_ff    <= minver_in;
         method_ff    <= method_in;
         swarm_len_ff <= swarm_len_in;
         window_ff    <= window_in;
         sup_len_ff   <= sup_len_in;
         chunk_ff     <= chunk_in;
         init_ff      <= init_in;
         out_valid_ff <= out_valid_in;
         out_ff       <= out_in;
      end
   end

   // a new result only appears as the parse closes
   `HOP_ASSERT_IMPLIES(a_result_at_done, clock, reset, $rose(out_valid_ff), phase_ff == PH_DONE, "result without finished parse")
   // a bad type byte always follows exactly four channel bytes
   `HOP_ASSERT_IMPLIES(a_bad_type_count, clock, reset, out_valid_ff && out_ff.outcome == OUT_BAD_TYPE, out_ff.bytes_consumed == 17'd4, "bad type count wrong")
   // a close request always ends after nine bytes
   `HOP_ASSERT_IMPLIES(a_close_count, clock, reset, out_valid_ff && out_ff.outcome == OUT_CLOSE, out_ff.bytes_consumed == 17'd9, "close count wrong")
   // skipping never sits on an empty count
   `HOP_ASSERT_IMPLIES(a_skip_nonzero, clock, reset, phase_ff == PH_SKIP, fcnt_ff != 16'd0, "skip count is zero")
   // a stalled result is not overwritten
   `HOP_ASSERT_NEXT(a_result_held, clock, reset, out_valid_ff && !rsp_ready, out_valid_ff && $stable(out_ff), "pending result lost")

endmodule

/* sv/handshake_option_parser.sv */
// ----------------------------------------------------------------------------
// handshake_option_parser
// Byte-stream parser for handshake datagrams: header channels, ordered
// options and the end option, one result per datagram.
//
//   channel   dir  payload
//   req_      in   tdata: data_byte; tuser: start_of_message; tlast: end_of_datagram
//   rsp_      out  tdata: channels, option values, bytes_consumed; tuser: outcome
//
// One request byte is taken per cycle while the front queue has room; the
// front queue absorbs bytes while a finished result waits on rsp_tready.
// A result follows its last byte through the queue register, then the
// result register loaded by the parse sequencer.
// Reset is synchronous: parse goes idle, option values return to zero.
// The sequencer advances only while the result register is free or drained.
// ----------------------------------------------------------------------------
module handshake_option_parser
   import hop_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] data_byte
   input  logic [0:0]            req_tuser,   // [0] start_of_message
   input  logic                  req_tlast,   // end_of_datagram
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [31:0] dest_channel, [63:32] src_channel, [71:64] version,
   // [79:72] oldest_version, [95:80] swarm_id_length, [127:96] method_codes,
   // [191:128] discard_window, [199:192] supported_length,
   // [231:200] chunk_length, [248:232] bytes_consumed, [255:249] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [2:0]            rsp_tuser    // [2:0] outcome
);

   logic           q_full;
   logic           q_push;
   hop_item_type   q_push_item;
   logic           q_pop;
   logic           q_valid;
   hop_item_type   q_item;
   hop_result_type result;

   hop_front u_front (
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_data  (req_tdata),
      .req_start (req_tuser[0]),
      .req_last  (req_tlast),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_item    (q_push_item)
   );

   hop_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_item  (q_item)
   );

   hop_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (result)
   );

   // result packing, first field lowest
   assign rsp_tuser = result.outcome;
   assign rsp_tdata = {7'd0,
                       result.bytes_consumed,
                       result.chunk_length,
                       result.supported_length,
                       result.discard_window,
                       result.method_codes,
                       result.swarm_id_length,
                       result.oldest_version,
                       result.version,
                       result.src_channel,
                       result.dest_channel};

endmodule

/* tb/handshake_option_parser_test.sv */
// ----------------------------------------------------------------------------
// handshake_option_parser_test
// Streams handshake datagrams into the option parser one byte per request,
// keeps its own copy of the parse state to predict every result, and checks
// each result field by field. Directed datagrams cover the edge cases, then
// random datagrams (mostly well formed) run with random gaps on both sides.
// ----------------------------------------------------------------------------
module handshake_option_parser_test
   import hop_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // option codes in the order a datagram carries them
   localparam int OPT_VERSION      = 0;
   localparam int OPT_MIN_VERSION  = 1;
   localparam int OPT_SWARM_ID     = 2;
   localparam int OPT_CONTENT_PROT = 3;
   localparam int OPT_MERKLE_HASH  = 4;
   localparam int OPT_SIGNATURE    = 5;
   localparam int OPT_CHUNK_ADDR   = 6;
   localparam int OPT_WINDOW       = 7;
   localparam int OPT_SUPPORTED    = 8;
   localparam int OPT_CHUNK_SIZE   = 9;

   localparam int RANDOM_ITEMS  = 250;
   localparam int HOLD_CYCLES   = 300;
   localparam int STALL_LIMIT   = 3000;
   localparam int DRAIN_CYCLES  = 20;

   typedef enum logic [3:0] {
      PH_IDLE, PH_DEST, PH_TYPE, PH_SRC, PH_CODE, PH_BYTEVAL, PH_SWLEN,
      PH_SKIP, PH_WINDOW, PH_SUPLEN, PH_CHUNK, PH_DONE
   } parse_phase_type;

   // parse state mirror and queue of results still owed by the block
   class handshake_scoreboard_type;
      parse_phase_type phase;
      logic [3:0]      next_code;
      logic [15:0]     bytes_left;
      logic [16:0]     consumed;
      logic [63:0]     shift_acc;
      logic [31:0]     dest_channel;
      logic [31:0]     src_channel;
      logic [7:0]      version;
      logic [7:0]      oldest_version;
      logic [31:0]     method_codes;
      logic [15:0]     swarm_length;
      logic [63:0]     window;
      logic [7:0]      supported_length;
      logic [31:0]     chunk_length;
      bit              is_init;
      hop_result_type  expected_results[$];
      int              errors;

      function new();
         phase = PH_IDLE;
         next_code = '0;
         bytes_left = '0;
         consumed = '0;
         shift_acc = '0;
         dest_channel = '0;
         src_channel = '0;
         version = '0;
         oldest_version = '0;
         method_codes = '0;
         swarm_length = '0;
         window = '0;
         supported_length = '0;
         chunk_length = '0;
         is_init = 0;
         errors = 0;
      endfunction

      function void open_field(logic [15:0] n, parse_phase_type next_phase);
         shift_acc = '0;
         bytes_left = n;
         phase = next_phase;
      endfunction

      // shift one byte in, true once the field is complete
      function bit shift_byte(logic [7:0] b);
         shift_acc = {shift_acc[55:0], b};
         bytes_left = bytes_left - 16'd1;
         return bytes_left == 16'd0;
      endfunction

      // returns 1 when the byte took part in a parse
      function bit note_request(logic [7:0] b, bit s, bit l);
         hop_result_type res;
         logic [2:0]     outcome;
         bit             done;
         done = 0;
         outcome = OUT_INIT;
         if (s) begin
            dest_channel = '0;
            src_channel = '0;
            consumed = '0;
            next_code = '0;
            is_init = 0;
            open_field(16'd4, PH_DEST);
         end
         if (phase == PH_IDLE || phase == PH_DONE)
            return 0;
         consumed = consumed + 17'd1;

         case (phase)
            PH_DEST: begin
               if (shift_byte(b)) begin
                  dest_channel = shift_acc[31:0];
                  phase = PH_TYPE;
               end
            end
            PH_TYPE: begin
               if (b != HANDSHAKE_TYPE) begin
                  outcome = OUT_BAD_TYPE;
                  done = 1;
                  consumed = consumed - 17'd1;
               end else begin
                  open_field(16'd4, PH_SRC);
               end
            end
            PH_SRC: begin
               if (shift_byte(b)) begin
                  src_channel = shift_acc[31:0];
                  if (dest_channel != 0 && src_channel == 0) begin
                     outcome = OUT_CLOSE;
                     done = 1;
                  end else begin
                     is_init = (dest_channel == 0 && src_channel != 0);
                     phase = PH_CODE;
                  end
               end
            end
            PH_CODE: begin
               if (b == END_CODE) begin
                  outcome = is_init ? OUT_INIT : OUT_NOT_INIT;
                  done = 1;
               end else if (b >= {4'd0, next_code} && b <= LAST_CODE) begin
                  next_code = b[3:0] + 4'd1;
                  case (b)
                     OPT_SWARM_ID: open_field(16'd2, PH_SWLEN);
                     OPT_WINDOW: begin
                        case (method_codes[7:0])
                           8'd0, 8'd2:       open_field(16'd4, PH_WINDOW);
                           8'd1, 8'd3, 8'd4: open_field(16'd8, PH_WINDOW);
                           default: begin
                              outcome = OUT_BAD_METHOD;
                              done = 1;
                           end
                        endcase
                     end
                     OPT_SUPPORTED:  phase = PH_SUPLEN;
                     OPT_CHUNK_SIZE: open_field(16'd4, PH_CHUNK);
                     default:        phase = PH_BYTEVAL;
                  endcase
               end else begin
                  // out of order or unknown code, not counted
                  outcome = OUT_NO_END;
                  done = 1;
                  consumed = consumed - 17'd1;
               end
            end
            PH_BYTEVAL: begin
               case (next_code)
                  OPT_VERSION + 1:      version = b;
                  OPT_MIN_VERSION + 1:  oldest_version = b;
                  OPT_CONTENT_PROT + 1: method_codes[31:24] = b;
                  OPT_MERKLE_HASH + 1:  method_codes[23:16] = b;
                  OPT_SIGNATURE + 1:    method_codes[15:8] = b;
                  default:              method_codes[7:0] = b;
               endcase
               phase = PH_CODE;
            end
            PH_SWLEN: begin
               if (shift_byte(b)) begin
                  swarm_length = shift_acc[15:0];
                  if (swarm_length == 0)
                     phase = PH_CODE;
                  else
                     open_field(swarm_length, PH_SKIP);
               end
            end
            PH_SKIP: begin
               bytes_left = bytes_left - 16'd1;
               if (bytes_left == 0)
                  phase = PH_CODE;
            end
            PH_WINDOW: begin
               if (shift_byte(b)) begin
                  window = shift_acc;
                  phase = PH_CODE;
               end
            end
            PH_SUPLEN: begin
               supported_length = b;
               if (b == 0)
                  phase = PH_CODE;
               else
                  open_field({8'd0, b}, PH_SKIP);
            end
            default: begin
               if (shift_byte(b)) begin
                  chunk_length = shift_acc[31:0];
                  phase = PH_CODE;
               end
            end
         endcase

         // last byte of an unfinished parse
         if (!done && l) begin
            outcome = OUT_TRUNCATED;
            done = 1;
         end
         if (done) begin
            phase = PH_DONE;
            res.outcome = outcome;
            res.dest_channel = dest_channel;
            res.src_channel = src_channel;
            res.version = version;
            res.oldest_version = oldest_version;
            res.swarm_id_length = swarm_length;
            res.method_codes = method_codes;
            res.discard_window = window;
            res.supported_length = supported_length;
            res.chunk_length = chunk_length;
            res.bytes_consumed = consumed;
            expected_results.push_back(res);
         end
         return 1;
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(logic [RSP_DATA_W-1:0] d, logic [2:0] u);
         hop_result_type want;
         if (expected_results.size() == 0) begin
            $error("outcome: expected none, actual %0d", u);
            errors++;
            return;
         end
         want = expected_results.pop_front();
         compare_field("outcome", want.outcome, u);
         compare_field("dest_channel", want.dest_channel, d[31:0]);
         compare_field("src_channel", want.src_channel, d[63:32]);
         compare_field("version", want.version, d[71:64]);
         compare_field("oldest_version", want.oldest_version, d[79:72]);
         compare_field("swarm_id_length", want.swarm_id_length, d[95:80]);
         compare_field("method_codes", want.method_codes, d[127:96]);
         compare_field("discard_window", want.discard_window, d[191:128]);
         compare_field("supported_length", want.supported_length, d[199:192]);
         compare_field("chunk_length", want.chunk_length, d[231:200]);
         compare_field("bytes_consumed", want.bytes_consumed, d[248:232]);
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = '0;   // [7:0] data_byte
   logic [0:0]            req_tuser = '0;   // [0] start_of_message
   logic                  req_tlast = 1'b0; // end_of_datagram
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // channels, options, bytes_consumed
   logic [2:0]            rsp_tuser;        // [2:0] outcome

   handshake_scoreboard_type sb = new();
   logic [7:0] frame[$];
   int  parsed_bytes = 0;
   int  gap_pct = 0;
   bit  calm = 0;
   bit  jitter = 0;
   bit  hold_armed = 0;

   always #2 clock = ~clock;

   handshake_option_parser u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // datagram building
   function void put_be(logic [63:0] v, int n);
      for (int i = n - 1; i >= 0; i--)
         frame.push_back(v[8*i +: 8]);
   endfunction

   function void put_header(logic [31:0] dest, logic [7:0] kind, logic [31:0] src);
      frame.delete();
      put_be(dest, 4);
      frame.push_back(kind);
      put_be(src, 4);
   endfunction

   function logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hff;
         default: return 8'($urandom);
      endcase
   endfunction

   function logic [31:0] pick_word();
      case ($urandom_range(0, 7))
         0, 1:    return 32'h0;
         2:       return 32'hffff_ffff;
         3:       return 32'($urandom_range(1, 255));
         default: return $urandom;
      endcase
   endfunction

   // random options in ascending order; bad_at places a bad code there
   function void put_options(logic [7:0] method_now, bit with_end, int bad_at);
      logic [7:0] m;
      int         n;
      int         last_taken;
      m = method_now;
      last_taken = -1;
      for (int c = OPT_VERSION; c <= OPT_CHUNK_SIZE; c++) begin
         if (c == bad_at) begin
            if (last_taken >= 0 && $urandom_range(0, 1))
               put_be($urandom_range(0, last_taken), 1);
            else
               put_be($urandom_range(LAST_CODE + 1, END_CODE - 1), 1);
            put_be(END_CODE, 1);
            return;
         end
         if ($urandom_range(0, 1)) begin
            put_be(c, 1);
            last_taken = c;
            case (c)
               OPT_SWARM_ID: begin
                  n = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
                  put_be(n, 2);
                  repeat (n) frame.push_back(pick_byte());
               end
               OPT_CHUNK_ADDR: begin
                  m = $urandom_range(0, 6) == 0 ? pick_byte() : 8'($urandom_range(0, 4));
                  frame.push_back(m);
               end
               OPT_WINDOW: put_be({$urandom, $urandom}, (m == 1 || m == 3 || m == 4) ? 8 : 4);
               OPT_SUPPORTED: begin
                  case ($urandom_range(0, 9))
                     0:       n = 0;
                     1:       n = $urandom_range(0, 255);
                     default: n = $urandom_range(1, 5);
                  endcase
                  put_be(n, 1);
                  repeat (n) frame.push_back(pick_byte());
               end
               OPT_CHUNK_SIZE: put_be(pick_word(), 4);
               default:        frame.push_back(pick_byte());
            endcase
         end
      end
      if (with_end)
         put_be(END_CODE, 1);
   endfunction

   // one request byte, with an optional gap before it
   task automatic send_byte(logic [7:0] b, bit s, bit l);
      if (!calm && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tuser <= s;
      req_tlast <= l;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (sb.note_request(b, s, l))
         parsed_bytes++;
   endtask

   task automatic send_frame(bit with_start, bit with_last);
      bit s;
      bit l;
      for (int i = 0; i < frame.size(); i++) begin
         s = with_start && i == 0;
         l = with_last && i == frame.size() - 1;
         // stray flags inside a datagram
         if (jitter && $urandom_range(0, 299) == 0) s = 1;
         if (jitter && $urandom_range(0, 199) == 0) l = 1;
         send_byte(frame[i], s, l);
      end
   endtask

   // result side: random stalls plus one long hold-off
   initial begin : receiver
      int  stall_pct;
      bit  held;
      stall_pct = 20;
      held = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_armed && !held) begin
            held = 1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!calm && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         if ($urandom_range(0, 63) == 0) begin
            case ($urandom_range(0, 2))
               0:       stall_pct = 0;
               1:       stall_pct = 15;
               default: stall_pct = 40;
            endcase
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata, rsp_tuser);
   end

   // watchdog on cycles with no handshake at all
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      int k;
      int keep;
      logic [31:0] dest;
      logic [31:0] src;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // bytes before any start are ignored
      frame.delete();
      frame.push_back(8'h00);
      frame.push_back(8'hff);
      frame.push_back(8'h5a);
      send_frame(0, 1);

      // init with every option present, most at an extreme, end flag on the end option
      put_header(32'h0, HANDSHAKE_TYPE, 32'hffff_ffff);
      put_be(OPT_VERSION, 1);      put_be(8'hff, 1);
      put_be(OPT_MIN_VERSION, 1);  put_be(8'h00, 1);
      put_be(OPT_SWARM_ID, 1);     put_be(16'h0, 2);
      put_be(OPT_CONTENT_PROT, 1); put_be(8'hff, 1);
      put_be(OPT_MERKLE_HASH, 1);  put_be(8'h00, 1);
      put_be(OPT_SIGNATURE, 1);    put_be(8'hff, 1);
      put_be(OPT_CHUNK_ADDR, 1);   put_be(8'd1, 1);
      put_be(OPT_WINDOW, 1);       put_be(64'hffff_ffff_ffff_ffff, 8);
      put_be(OPT_SUPPORTED, 1);    put_be(8'h0, 1);
      put_be(OPT_CHUNK_SIZE, 1);   put_be(32'hffff_ffff, 4);
      put_be(END_CODE, 1);
      send_frame(1, 1);

      // not init, skipped bytes, four byte window
      put_header(32'hffff_ffff, HANDSHAKE_TYPE, 32'hffff_ffff);
      put_be(OPT_SWARM_ID, 1);     put_be(16'd3, 2); put_be(24'hff00ff, 3);
      put_be(OPT_CHUNK_ADDR, 1);   put_be(8'd2, 1);
      put_be(OPT_WINDOW, 1);       put_be(32'ha5a5_5a5a, 4);
      put_be(OPT_SUPPORTED, 1);    put_be(8'd2, 1); put_be(16'hffff, 2);
      put_be(END_CODE, 1);
      send_frame(1, 1);

      // close request, trailing bytes ignored
      put_header(32'h1, HANDSHAKE_TYPE, 32'h0);
      put_be(END_CODE, 1);
      send_frame(1, 1);

      // bad type byte
      put_header(32'h1234_5678, 8'hff, 32'h1);
      send_frame(1, 1);

      // chunk addressing method out of range, then a window option
      put_header(32'h0, HANDSHAKE_TYPE, 32'h7);
      put_be(OPT_CHUNK_ADDR, 1);   put_be(8'd5, 1);
      put_be(OPT_WINDOW, 1);       put_be(32'h0, 4);
      send_frame(1, 1);

      // codes out of order
      put_header(32'h0, HANDSHAKE_TYPE, 32'h2);
      put_be(OPT_CONTENT_PROT, 1); put_be(8'h11, 1);
      put_be(OPT_MIN_VERSION, 1);  put_be(8'h22, 1);
      send_frame(1, 1);

      // unknown code above the last option
      put_header(32'h0, HANDSHAKE_TYPE, 32'h3);
      put_be(LAST_CODE + 1, 1);
      send_frame(1, 1);

      // truncated inside the destination channel
      put_header(32'hdead_beef, HANDSHAKE_TYPE, 32'h0);
      frame = frame[0:1];
      send_frame(1, 1);

      // start and end on the same byte
      frame.delete();
      frame.push_back(8'h80);
      send_frame(1, 1);

      // datagram abandoned mid-header, then restarted
      put_header(32'h0, HANDSHAKE_TYPE, 32'h0);
      frame = frame[0:5];
      send_frame(1, 0);
      put_header(32'h0, HANDSHAKE_TYPE, 32'h0);
      put_be(OPT_CHUNK_ADDR, 1);   put_be(8'd0, 1);
      put_be(END_CODE, 1);
      send_frame(1, 1);

      // swarm id length with both bytes set, then a shorter bitmap
      gap_pct = 5;
      put_header(32'h0, HANDSHAKE_TYPE, 32'h1);
      put_be(OPT_SWARM_ID, 1);     put_be(16'h0101, 2);
      repeat (257) frame.push_back(8'($urandom));
      put_be(OPT_SUPPORTED, 1);    put_be(8'h40, 1);
      repeat (64) frame.push_back(8'($urandom));
      put_be(OPT_CHUNK_SIZE, 1);   put_be(32'h0001_0000, 4);
      put_be(END_CODE, 1);
      send_frame(1, 1);

      // random datagrams
      parsed_bytes = 0;
      jitter = 1;
      hold_armed = 1;
      while (parsed_bytes < RANDOM_ITEMS) begin
         if (parsed_bytes >= RANDOM_ITEMS * 7 / 8)
            calm = 1;
         case ($urandom_range(0, 3))
            0:       gap_pct = 0;
            1:       gap_pct = 10;
            default: gap_pct = 35;
         endcase
         k = $urandom_range(0, 99);
         dest = pick_word();
         src = pick_word();
         if ($urandom_range(0, 2) == 0)
            dest = 32'h0;
         if (k < 50) begin
            // well formed handshake
            if (dest != 0 && src == 0 && $urandom_range(0, 3) != 0)
               src = 32'h1;
            put_header(dest, HANDSHAKE_TYPE, src);
            put_options(sb.method_codes[7:0], 1, -1);
            send_frame(1, 1);
         end else if (k < 58) begin
            // close request, maybe with options that are never read
            put_header(dest == 0 ? 32'h1 : dest, HANDSHAKE_TYPE, 32'h0);
            if ($urandom_range(0, 1))
               put_options(sb.method_codes[7:0], 1, -1);
            send_frame(1, 1);
         end else if (k < 65) begin
            put_header(dest, 8'($urandom_range(1, 255)), src);
            send_frame(1, 1);
         end else if (k < 75) begin
            put_header(dest, HANDSHAKE_TYPE, src);
            put_options(sb.method_codes[7:0], 1, $urandom_range(OPT_VERSION, OPT_CHUNK_SIZE));
            send_frame(1, 1);
         end else if (k < 87) begin
            // truncated anywhere, sometimes just short of the end option
            put_header(dest, HANDSHAKE_TYPE, src);
            put_options(sb.method_codes[7:0], $urandom_range(0, 1), -1);
            keep = $urandom_range(1, frame.size());
            while (frame.size() > keep) void'(frame.pop_back());
            send_frame(1, 1);
         end else if (k < 93) begin
            // abandoned without an end flag, the next start restarts
            put_header(dest, HANDSHAKE_TYPE, src);
            put_options(sb.method_codes[7:0], 0, -1);
            keep = $urandom_range(1, frame.size());
            while (frame.size() > keep) void'(frame.pop_back());
            send_frame(1, 0);
         end else begin
            // noise with no start
            frame.delete();
            repeat ($urandom_range(1, 4)) frame.push_back(pick_byte());
            send_frame(0, $urandom_range(0, 1));
         end
      end

      req_tvalid <= 1'b0;
      while (sb.expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.expected_results.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+sv
sv/hop_pkg.sv
sv/hop_front.sv
sv/hop_queue.sv
sv/hop_back.sv
sv/handshake_option_parser.sv
tb/handshake_option_parser_test.sv
